### src/kcg_pkg.sv
// shared constants, types and channel codes for the keyframe color gradient
`default_nettype none

package kcg_pkg;

    // keyframe count and field widths
    localparam int KEYFRAMES = 4;
    localparam int POS_W     = 16;
    localparam int CH_W      = 8;
    localparam int CHANNELS  = 3;
    localparam int KF_W      = POS_W + CHANNELS * CH_W;
    localparam int KF_IDX_W  = (KEYFRAMES > 1) ? $clog2(KEYFRAMES) : 1;

    // interpolation widths: span and offset fit in one bit more than a position
    localparam int SPAN_W    = POS_W + 1;
    localparam int NUM_W     = SPAN_W + CH_W;
    localparam int DIV_STEPS = CH_W;

    // channel slots inside a packed color
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [CHANNELS-1:0][CH_W-1:0] color_t;

    // one keyframe, packed as in its configuration register
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        color_t                  color;
    } kf_t;

    typedef kf_t [KEYFRAMES-1:0] kf_bank_t;

    // chosen segment handed from the selector to the interpolator
    typedef struct packed {
        logic              direct;
        logic [SPAN_W-1:0] delta;
        logic [SPAN_W-1:0] span;
        color_t            lo;
        color_t            hi;
    } seg_t;

endpackage

`default_nettype wire

### src/kcg_kf_regs.sv
// keyframe configuration registers
`default_nettype none

module kcg_kf_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [kcg_pkg::KF_IDX_W-1:0]  cfg_index,
    input  wire logic [kcg_pkg::KF_W-1:0]      cfg_data,
    output      kcg_pkg::kf_bank_t             kf_bank
);
    import kcg_pkg::*;

    kf_bank_t kf_bank_reg;
    kf_bank_t kf_bank_next;

    // decode the index; indexes past the last keyframe match nothing
    always_comb
    begin
        kf_bank_next = kf_bank_reg;
        for (int k = 0; k < KEYFRAMES; k++)
        begin
            if (cfg_we && (cfg_index == KF_IDX_W'(k)))
            begin
                kf_bank_next[k] = kf_t'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kf_bank_reg <= '0;
        end
        else
        begin
            kf_bank_reg <= kf_bank_next;
        end
    end

    assign kf_bank = kf_bank_reg;

endmodule

`default_nettype wire

### src/kcg_segment.sv
// two-stage segment selector: compares, then pair choice and span/offset
`default_nettype none

module kcg_segment (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [kcg_pkg::POS_W-1:0]  position,
    input  wire kcg_pkg::kf_bank_t                 kf_bank,
    output      logic                              out_valid,
    output      kcg_pkg::seg_t                     seg
);
    import kcg_pkg::*;

    // stage a: position against every keyframe
    logic                    a_valid_reg;
    logic signed [POS_W-1:0] a_pos_reg;
    logic [KEYFRAMES-1:0]    a_ge_reg;
    logic [KEYFRAMES-1:0]    a_le_reg;
    logic [KEYFRAMES-1:0]    a_ge_next;
    logic [KEYFRAMES-1:0]    a_le_next;

    // stage b: chosen segment
    logic                    b_valid_reg;
    seg_t                    b_seg_reg;
    seg_t                    b_seg_next;

    logic                    found;
    logic signed [POS_W-1:0] pos_lo;
    logic signed [POS_W-1:0] pos_hi;
    color_t                  col_lo;
    color_t                  col_hi;
    logic [SPAN_W-1:0]       span;
    logic [SPAN_W-1:0]       delta;

    always_comb
    begin
        for (int k = 0; k < KEYFRAMES; k++)
        begin
            a_ge_next[k] = (position >= kf_bank[k].pos);
            a_le_next[k] = (position <= kf_bank[k].pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pos_reg <= position;
        a_ge_reg  <= a_ge_next;
        a_le_reg  <= a_le_next;
    end

    // first bracketing pair wins: scan downward so the lowest match is kept
    always_comb
    begin
        found  = 1'b0;
        pos_lo = '0;
        pos_hi = '0;
        col_lo = '0;
        col_hi = '0;
        for (int k = KEYFRAMES - 2; k >= 0; k--)
        begin
            if (a_ge_reg[k] && a_le_reg[k+1])
            begin
                found  = 1'b1;
                pos_lo = kf_bank[k].pos;
                pos_hi = kf_bank[k+1].pos;
                col_lo = kf_bank[k].color;
                col_hi = kf_bank[k+1].color;
            end
        end
    end

    // span and offset inside the pair, both non-negative when found
    assign span  = {pos_hi[POS_W-1], pos_hi} - {pos_lo[POS_W-1], pos_lo};
    assign delta = {a_pos_reg[POS_W-1], a_pos_reg} - {pos_lo[POS_W-1], pos_lo};

    // clamps, zero-width pair and no pair all pass a color straight through
    always_comb
    begin
        b_seg_next.delta  = delta;
        b_seg_next.span   = span;
        b_seg_next.hi     = col_hi;
        b_seg_next.direct = 1'b1;
        b_seg_next.lo     = '0;
        if (a_le_reg[0])
        begin
            b_seg_next.lo = kf_bank[0].color;
        end
        else if (a_ge_reg[KEYFRAMES-1])
        begin
            b_seg_next.lo = kf_bank[KEYFRAMES-1].color;
        end
        else if (found)
        begin
            b_seg_next.lo     = col_lo;
            b_seg_next.direct = (span == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_seg_reg <= b_seg_next;
    end

    assign out_valid = b_valid_reg;
    assign seg       = b_seg_reg;

`ifndef SYNTH
    // an interpolated segment has a nonzero span that covers the offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_seg_reg.direct) |->
            ((b_seg_reg.delta <= b_seg_reg.span) && (b_seg_reg.span != '0)))
        else $error("segment offset outside its span");

    // a word leaves the selector after the stage a and stage b registers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 2))
        else $error("selector latency broken");
`endif

endmodule

`default_nettype wire

### src/kcg_interp.sv
// interpolator: difference times offset, pipelined restoring divide, add/sub
`default_nettype none

module kcg_interp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              seg_valid,
    input  wire kcg_pkg::seg_t     seg,
    output      logic              out_valid,
    output      kcg_pkg::color_t   color
);
    import kcg_pkg::*;

    // multiply stage
    logic                              m_valid_reg;
    logic                              m_direct_reg;
    logic [SPAN_W-1:0]                 m_span_reg;
    color_t                            m_lo_reg;
    logic [CHANNELS-1:0]               m_neg_reg;
    logic [CHANNELS-1:0][NUM_W-1:0]    m_num_reg;
    logic [CHANNELS-1:0]               m_neg_next;
    logic [CHANNELS-1:0][NUM_W-1:0]    m_num_next;
    logic [CHANNELS-1:0][CH_W-1:0]     mag;

    // divide stages, one quotient bit each
    logic                              d_valid_reg  [DIV_STEPS];
    logic                              d_direct_reg [DIV_STEPS];
    logic [SPAN_W-1:0]                 d_span_reg   [DIV_STEPS];
    color_t                            d_lo_reg     [DIV_STEPS];
    logic [CHANNELS-1:0]               d_neg_reg    [DIV_STEPS];
    logic [CHANNELS-1:0][NUM_W-1:0]    d_rem_reg    [DIV_STEPS];
    logic [CHANNELS-1:0][CH_W-1:0]     d_q_reg      [DIV_STEPS];

    logic                              s_valid  [DIV_STEPS];
    logic                              s_direct [DIV_STEPS];
    logic [SPAN_W-1:0]                 s_span   [DIV_STEPS];
    color_t                            s_lo     [DIV_STEPS];
    logic [CHANNELS-1:0]               s_neg    [DIV_STEPS];
    logic [CHANNELS-1:0][NUM_W-1:0]    s_rem    [DIV_STEPS];
    logic [CHANNELS-1:0][CH_W-1:0]     s_q      [DIV_STEPS];

    logic [CHANNELS-1:0][NUM_W-1:0]    d_rem_next [DIV_STEPS];
    logic [CHANNELS-1:0][CH_W-1:0]     d_q_next   [DIV_STEPS];
    logic [NUM_W-1:0]                  shifted    [DIV_STEPS];

    // output stage
    logic                              o_valid_reg;
    color_t                            o_color_reg;
    color_t                            o_color_next;

    // channel difference as sign and magnitude, then offset times magnitude
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            m_neg_next[c] = (seg.hi[c] < seg.lo[c]);
            mag[c]        = m_neg_next[c] ? (seg.lo[c] - seg.hi[c])
                                          : (seg.hi[c] - seg.lo[c]);
            m_num_next[c] = NUM_W'(seg.delta) * NUM_W'(mag[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_direct_reg <= seg.direct;
        m_span_reg   <= seg.span;
        m_lo_reg     <= seg.lo;
        m_neg_reg    <= m_neg_next;
        m_num_reg    <= m_num_next;
    end

    // stage inputs: the multiply stage feeds the first divide stage
    always_comb
    begin
        s_valid[0]  = m_valid_reg;
        s_direct[0] = m_direct_reg;
        s_span[0]   = m_span_reg;
        s_lo[0]     = m_lo_reg;
        s_neg[0]    = m_neg_reg;
        s_rem[0]    = m_num_reg;
        s_q[0]      = '0;
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            s_valid[s]  = d_valid_reg[s-1];
            s_direct[s] = d_direct_reg[s-1];
            s_span[s]   = d_span_reg[s-1];
            s_lo[s]     = d_lo_reg[s-1];
            s_neg[s]    = d_neg_reg[s-1];
            s_rem[s]    = d_rem_reg[s-1];
            s_q[s]      = d_q_reg[s-1];
        end
    end

    // quotient is below 256 because the offset never exceeds the span
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            shifted[s] = NUM_W'(s_span[s]) << (DIV_STEPS - 1 - s);
            for (int c = 0; c < CHANNELS; c++)
            begin
                d_rem_next[s][c] = s_rem[s][c];
                d_q_next[s][c]   = s_q[s][c];
                if (s_rem[s][c] >= shifted[s])
                begin
                    d_rem_next[s][c] = s_rem[s][c] - shifted[s];
                    d_q_next[s][c][DIV_STEPS - 1 - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                d_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                d_valid_reg[s] <= s_valid[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            d_direct_reg[s] <= s_direct[s];
            d_span_reg[s]   <= s_span[s];
            d_lo_reg[s]     <= s_lo[s];
            d_neg_reg[s]    <= s_neg[s];
            d_rem_reg[s]    <= d_rem_next[s];
            d_q_reg[s]      <= d_q_next[s];
        end
    end

    // floor division: a falling channel rounds away when there is a remainder
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (d_direct_reg[DIV_STEPS-1])
            begin
                o_color_next[c] = d_lo_reg[DIV_STEPS-1][c];
            end
            else if (d_neg_reg[DIV_STEPS-1][c])
            begin
                o_color_next[c] = d_lo_reg[DIV_STEPS-1][c] - d_q_reg[DIV_STEPS-1][c]
                                - CH_W'(d_rem_reg[DIV_STEPS-1][c] != '0);
            end
            else
            begin
                o_color_next[c] = d_lo_reg[DIV_STEPS-1][c] + d_q_reg[DIV_STEPS-1][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= d_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        o_color_reg <= o_color_next;
    end

    assign out_valid = o_valid_reg;
    assign color     = o_color_reg;

`ifndef SYNTH
    // a finished divide leaves every remainder below the span
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg[DIV_STEPS-1] && !d_direct_reg[DIV_STEPS-1]) |->
            ((d_rem_reg[DIV_STEPS-1][0] < NUM_W'(d_span_reg[DIV_STEPS-1])) &&
             (d_rem_reg[DIV_STEPS-1][1] < NUM_W'(d_span_reg[DIV_STEPS-1])) &&
             (d_rem_reg[DIV_STEPS-1][2] < NUM_W'(d_span_reg[DIV_STEPS-1]))))
        else $error("divider remainder not below span");

    // a word passes the multiply, divide and output stages of the interpolator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(seg_valid, 10))
        else $error("interpolator latency broken");
`endif

endmodule

`default_nettype wire

### src/keyframe_color_gradient_top.sv
// top level of the keyframe color gradient
// Maps a signed 16-bit position to an RGB color by piecewise-linear
// interpolation between four keyframes held in configuration registers.
// Input: a word is taken at each rising edge where start is high and busy
//   is low; busy stays low, so a new position can enter every cycle.
// Output: done marks red/green/blue for exactly one cycle, once the word has
//   passed the selector and interpolator stages; the receiver cannot hold
//   results back, and results leave in the order the positions came in.
// Throughput is one word per cycle. A word passes two selector stages,
//   one multiply stage, eight divide stages (one quotient bit each, since the
//   quotient of offset times channel difference over span is below 256) and
//   one output stage.
// Configuration: cfg_we writes cfg_data into keyframe cfg_index at the clock
//   edge; bits 39:24 position, 23:16 red, 15:8 green, 7:0 blue. Write only
//   while no word is in flight. Keyframe positions should not decrease.
// Reset clears all keyframes to zero and empties the pipeline.
`default_nettype none

module keyframe_color_gradient_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic signed [kcg_pkg::POS_W-1:0]  position,
    output      logic                              done,
    output      logic [kcg_pkg::CH_W-1:0]          red,
    output      logic [kcg_pkg::CH_W-1:0]          green,
    output      logic [kcg_pkg::CH_W-1:0]          blue,
    input  wire logic                              cfg_we,
    input  wire logic [kcg_pkg::KF_IDX_W-1:0]      cfg_index,
    input  wire logic [kcg_pkg::KF_W-1:0]          cfg_data
);
    import kcg_pkg::*;

    kf_bank_t kf_bank;
    logic     in_valid;
    logic     seg_valid;
    seg_t     seg;
    color_t   color;

    // the pipeline takes a word every cycle
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    // keyframe registers
    kcg_kf_regs u_kf_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kf_bank   (kf_bank)
    );

    // segment choice
    kcg_segment u_segment (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .position  (position),
        .kf_bank   (kf_bank),
        .out_valid (seg_valid),
        .seg       (seg)
    );

    // interpolation
    kcg_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg       (seg),
        .out_valid (done),
        .color     (color)
    );

    assign red   = color[CH_RED];
    assign green = color[CH_GREEN];
    assign blue  = color[CH_BLUE];

endmodule

`default_nettype wire
